// ----- hw/rtl/bsc_pkg.sv -----
// Shared constants and types for the B-spline curve point evaluator.
package bsc_pkg;

  localparam int MaxPoints = 64;
  localparam int MemAw     = $clog2(MaxPoints);
  localparam int CountW    = 7;
  localparam int CoordW    = 24;
  localparam int UW        = 22;
  localparam int FracW     = 16;
  localparam int MulW      = 34;
  localparam int ProdW     = 2 * MulW;
  localparam int AccW      = 58;
  localparam int BasisW    = 31;

  // Configuration register indexes
  localparam logic CfgDegree = 1'b0;
  localparam logic CfgCount  = 1'b1;

  // Input commands
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  // Reciprocal of three, exact for 32-bit dividends: (2^33 + 1) / 3
  localparam logic [31:0] RecipThree = 32'hAAAA_AAAB;

  typedef logic signed [MulW-1:0] mul_op_t;

endpackage

// ----- hw/rtl/bsc_if.sv -----
// Valid/ready channel interfaces for the evaluator input and result beats.
interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  point_index;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [21:0] param_u;

  modport source (output valid, cmd, point_index, point_x, point_y, param_u, input ready);
  modport sink   (input valid, cmd, point_index, point_x, point_y, param_u, output ready);
endinterface

interface bsc_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] curve_x;
  logic signed [23:0] curve_y;

  modport source (output valid, curve_x, curve_y, input ready);
  modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

// ----- hw/rtl/bsc_mul.sv -----
// Shared signed multiplier with a registered product.
module bsc_mul (
  input  logic                     clk_i,
  input  bsc_pkg::mul_op_t         op_a_i,
  input  bsc_pkg::mul_op_t         op_b_i,
  output logic signed [bsc_pkg::ProdW-1:0] prod_o
);
  import bsc_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  // One product per cycle, no reset on payload
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;
endmodule

// ----- hw/rtl/bsc_basis.sv -----
// Basis numerators from powers of the fraction, with their first scaling step.
module bsc_basis (
  input  logic [1:0]  deg_i,
  input  logic [1:0]  seg_i,
  input  logic [16:0] f_i,
  input  logic [31:0] f2_i,
  input  logic [47:0] f3_i,
  output logic [bsc_pkg::BasisW-1:0] basis_o,
  output logic [31:0] pre3_o
);
  import bsc_pkg::*;

  localparam logic [52:0] One32 = 53'd1 << 32;
  localparam logic [52:0] One48 = 53'd1 << 48;
  localparam logic [52:0] One50 = 53'd1 << 50;
  localparam logic [52:0] Half3 = 53'd786432;

  logic [52:0] f1w, f2w, f3w, n2, n3, r2, r3;
  logic [16:0] g;

  assign f1w = {36'd0, f_i};
  assign f2w = {21'd0, f2_i};
  assign f3w = {5'd0, f3_i};
  assign g   = 17'd65536 - f_i;

  // Quadratic numerators over 2*F^2
  always_comb begin
    unique case (seg_i)
      2'd0:    n2 = f2w;
      2'd1:    n2 = One32 + (f1w << 17) - (f2w << 1);
      default: n2 = One32 - (f1w << 17) + f2w;
    endcase
  end

  // Cubic numerators over 6*F^3
  always_comb begin
    unique case (seg_i)
      2'd0:    n3 = f3w;
      2'd1:    n3 = One48 + (3 * (f1w << 32)) + (3 * (f2w << 16)) - 3 * f3w;
      2'd2:    n3 = One50 + 3 * f3w - (6 * (f2w << 16));
      default: n3 = One48 - (3 * (f1w << 32)) + (3 * (f2w << 16)) - f3w;
    endcase
  end

  assign r2     = (n2 + 53'd4) >> 3;
  assign r3     = (n3 + Half3) >> 19;
  assign pre3_o = r3[31:0];

  // Linear is exact; quadratic is final here; cubic still needs the divide by three
  always_comb begin
    if (deg_i == 2'd2) begin
      basis_o = r2[BasisW-1:0];
    end else if (seg_i == 2'd0) begin
      basis_o = {f_i, 14'd0};
    end else begin
      basis_o = {g, 14'd0};
    end
  end
endmodule

// ----- hw/rtl/bspline_curve_point_eval.sv -----
// Top level: control point store, sequencer and accumulators of the B-spline evaluator.
// Sequence: an evaluation steps through StSq, StCu and StPw, then StSeg, StDiv, StBas,
//   StMx, StMy and StAy per point in reach of u, StSeg alone per skipped segment, then StFin.
// Throughput: one item at a time; the single shared multiplier sets the step count.
// Reset: rst_ni is asynchronous, active low; degree resets to 3, point_count to 0,
//   the point store is not cleared and reads undefined until written.
module bspline_curve_point_eval (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  bsc_in_if.sink     in_if,
  bsc_out_if.source  out_if
);
  import bsc_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq   = 4'd1;
  localparam logic [3:0] StCu   = 4'd2;
  localparam logic [3:0] StPw   = 4'd3;
  localparam logic [3:0] StSeg  = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StBas  = 4'd6;
  localparam logic [3:0] StMx   = 4'd7;
  localparam logic [3:0] StMy   = 4'd8;
  localparam logic [3:0] StAy   = 4'd9;
  localparam logic [3:0] StFin  = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [1:0]  degree_q;
  logic [6:0]  count_q;
  logic [1:0]  deg_q;
  logic [6:0]  cnt_q;
  logic [5:0]  ui_q;
  logic [16:0] f_q;
  logic [31:0] f2_q;
  logic [47:0] f3_q;
  logic [2:0]  seg_q;
  logic [31:0] pre_q;
  logic [BasisW-1:0] bas_q;
  logic signed [AccW-1:0] accx_q, accy_q;
  logic        ovld_q;
  logic signed [CoordW-1:0] ox_q, oy_q;

  logic [2*CoordW-1:0] mem_q [MaxPoints];
  logic [2*CoordW-1:0] rd_q;

  mul_op_t op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic [BasisW-1:0] basis;
  logic [31:0] pre3;
  logic [6:0]  idx;
  logic        seg_done, seg_skip, in_acc, fin_go;
  logic signed [CoordW-1:0] rnd_x, rnd_y;

  assign in_if.ready = (state_q == StIdle);
  assign in_acc      = in_if.valid && in_if.ready;
  assign fin_go      = !ovld_q || out_if.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 2'd3;
      count_q  <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDegree: degree_q <= cfg_data_i[1:0];
        CfgCount:  count_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Control point store: write on a write beat, read one entry per segment
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.cmd == CmdWrite) begin
      mem_q[in_if.point_index[MemAw-1:0]] <= {in_if.point_x, in_if.point_y};
    end
    if (state_q == StSeg) begin
      rd_q <= mem_q[idx[MemAw-1:0]];
    end
  end

  // Segment bookkeeping
  assign idx      = {1'b0, ui_q} - {4'd0, seg_q};
  assign seg_done = (seg_q > {1'b0, deg_q}) || (seg_q > 3'(ui_q) && ui_q < 6'd4);
  assign seg_skip = idx >= cnt_q;

  bsc_basis u_basis (
    .deg_i  (deg_q),
    .seg_i  (seg_q[1:0]),
    .f_i    (f_q),
    .f2_i   (f2_q),
    .f3_i   (f3_q),
    .basis_o(basis),
    .pre3_o (pre3)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      StSq: begin
        op_a = MulW'(f_q);
        op_b = MulW'(f_q);
      end
      StCu: begin
        op_a = {2'b00, prod[31:0]};
        op_b = MulW'(f_q);
      end
      StDiv: begin
        op_a = {2'b00, pre_q};
        op_b = {2'b00, RecipThree};
      end
      StMx: begin
        op_a = MulW'(signed'(rd_q[2*CoordW-1:CoordW]));
        op_b = MulW'(bas_q);
      end
      StMy: begin
        op_a = MulW'(signed'(rd_q[CoordW-1:0]));
        op_b = MulW'(bas_q);
      end
      default: ;
    endcase
  end

  bsc_mul u_mul (
    .clk_i (clk_i),
    .op_a_i(op_a),
    .op_b_i(op_b),
    .prod_o(prod)
  );

  // Round half up to Q8 and saturate
  function automatic logic signed [CoordW-1:0] rnd_sat(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] v;
    logic signed [AccW-31:0] r;
    v = a + (AccW'(1) <<< 29);
    r = v[AccW-1:30];
    if (r > (AccW-30)'(8388607)) begin
      rnd_sat = 24'sh7FFFFF;
    end else if (r < -(AccW-30)'(8388608)) begin
      rnd_sat = 24'sh800000;
    end else begin
      rnd_sat = r[CoordW-1:0];
    end
  endfunction

  assign rnd_x = rnd_sat(accx_q);
  assign rnd_y = rnd_sat(accy_q);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc && in_if.cmd == CmdEval) state_d = StSq;
      StSq:    state_d = StCu;
      StCu:    state_d = StPw;
      StPw:    state_d = StSeg;
      StSeg: begin
        if (seg_done) state_d = StFin;
        else if (!seg_skip) state_d = StDiv;
      end
      StDiv:   state_d = StBas;
      StBas:   state_d = StMx;
      StMx:    state_d = StMy;
      StMy:    state_d = StAy;
      StAy:    state_d = StSeg;
      StFin:   if (fin_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      seg_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        seg_q <= '0;
      end else if ((state_q == StSeg && !seg_done && seg_skip) || state_q == StAy) begin
        seg_q <= seg_q + 3'd1;
      end
      if (state_q == StFin && fin_go) begin
        ovld_q <= 1'b1;
      end else if (out_if.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.cmd == CmdEval) begin
      deg_q  <= (degree_q == 2'd0) ? 2'd1 : degree_q;
      cnt_q  <= (count_q > 7'(MaxPoints)) ? 7'(MaxPoints) : count_q;
      ui_q   <= in_if.param_u[UW-1:FracW];
      f_q    <= {1'b0, in_if.param_u[FracW-1:0]};
      accx_q <= '0;
      accy_q <= '0;
    end
    if (state_q == StCu) f2_q <= prod[31:0];
    if (state_q == StPw) f3_q <= prod[47:0];
    if (state_q == StSeg) begin
      pre_q <= pre3;
      bas_q <= basis;
    end
    if (state_q == StBas && deg_q == 2'd3) bas_q <= prod[63:33];
    if (state_q == StMy) accx_q <= accx_q + prod[AccW-1:0];
    if (state_q == StAy) accy_q <= accy_q + prod[AccW-1:0];
    if (state_q == StFin && fin_go) begin
      ox_q <= rnd_x;
      oy_q <= rnd_y;
    end
  end

  assign out_if.valid   = ovld_q;
  assign out_if.curve_x = ox_q;
  assign out_if.curve_y = oy_q;

  // The segment counter never passes the highest cubic segment plus one
  assert property (@(posedge clk_i) disable iff (!rst_ni) seg_q <= 3'd4)
    else $error("segment counter out of range");

  // A new result only comes out of the finishing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == StFin))
    else $error("result without finishing step");

  // The finishing step never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && ovld_q && !out_if.ready) |=> state_q == StFin)
    else $error("result overwritten");
endmodule

// ----- sim/bspline_curve_point_eval_tb.sv -----
// Testbench for the B-spline curve point evaluator: directed and random items, scoreboard check.
`timescale 1ns / 1ps

module bspline_curve_point_eval_tb;
  import bsc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = CfgDegree;
  logic [6:0] cfg_data_i = '0;

  bsc_in_if  in_if ();
  bsc_out_if out_if ();

  bspline_curve_point_eval u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         point_index;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [21:0]        param_u;
  } curve_req_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } curve_pt_t;

  // Shadow copy of the block state
  logic [1:0]         shadow_degree;
  logic [6:0]         shadow_count;
  logic signed [23:0] shadow_x [MaxPoints];
  logic signed [23:0] shadow_y [MaxPoints];

  curve_pt_t expected_pts [$];
  int        n_errors = 0;
  int        burst_left = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CmdWrite;
    in_if.point_index = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.param_u = '0;
    out_if.ready = 1'b0;
  end

  // Uniform basis weight in Q30 for segment seg and fraction frac
  function automatic longint unsigned basis_weight(int deg, int seg, longint unsigned frac);
    longint unsigned one, g, n;
    one = 65536;
    g = one - frac;
    if (deg == 1) return ((seg == 0) ? frac : g) << 14;
    if (deg == 2) begin
      if (seg == 0) n = frac * frac;
      else if (seg == 1) n = one * one + 2 * frac * one - 2 * frac * frac;
      else n = g * g;
      return (n + 4) >> 3;
    end
    if (seg == 0) n = frac * frac * frac;
    else if (seg == 1)
      n = 3 * frac * frac * one + 3 * frac * one * one + one * one * one
          - 3 * frac * frac * frac;
    else if (seg == 2) n = 3 * frac * frac * frac + 4 * one * one * one - 6 * frac * frac * one;
    else n = g * g * g;
    return (n + 3 * 262144) / (6 * 262144);
  endfunction

  // Q38 sum to Q8, half toward plus infinity, saturated
  function automatic logic signed [23:0] round_q38(longint acc);
    longint r;
    r = (acc + (longint'(1) <<< 29)) >>> 30;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  // Update the shadow state for an accepted write beat, or queue the curve point of an evaluation
  task automatic predict_curve(curve_req_t req);
    int deg, cnt, ui, idx;
    longint unsigned frac, w;
    longint ax, ay;
    curve_pt_t pt;
    if (req.cmd == CmdWrite) begin
      shadow_x[req.point_index] = req.point_x;
      shadow_y[req.point_index] = req.point_y;
      return;
    end
    deg = (shadow_degree == 0) ? 1 : int'(shadow_degree);
    cnt = (shadow_count > MaxPoints) ? MaxPoints : int'(shadow_count);
    ui = int'(req.param_u[21:16]);
    frac = longint'(req.param_u[15:0]);
    ax = 0;
    ay = 0;
    for (int s = 0; s <= deg; s++) begin
      if (s > ui) break;
      idx = ui - s;
      if (idx >= cnt) continue;
      w = basis_weight(deg, s, frac);
      ax += longint'(shadow_x[idx[5:0]]) * longint'(w);
      ay += longint'(shadow_y[idx[5:0]]) * longint'(w);
    end
    pt.x = round_q38(ax);
    pt.y = round_q38(ay);
    expected_pts = {expected_pts, pt};
  endtask

  // Send one beat; bursts with random gaps; called at a rising edge
  task automatic send_req(curve_req_t req);
    logic rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.cmd <= req.cmd;
    in_if.point_index <= req.point_index;
    in_if.point_x <= req.point_x;
    in_if.point_y <= req.point_y;
    in_if.param_u <= req.param_u;
    forever begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
      if (rdy) break;
    end
    predict_curve(req);
  endtask

  task automatic write_point(int idx, logic signed [23:0] x, logic signed [23:0] y);
    curve_req_t req;
    req = '0;
    req.cmd = CmdWrite;
    req.point_index = 6'(idx);
    req.point_x = x;
    req.point_y = y;
    req.param_u = 22'($urandom());
    send_req(req);
  endtask

  task automatic eval_at(logic [21:0] u);
    curve_req_t req;
    req = '0;
    req.cmd = CmdEval;
    req.point_index = 6'($urandom());
    req.point_x = 24'($urandom());
    req.point_y = 24'($urandom());
    req.param_u = u;
    send_req(req);
  endtask

  // Drain results and wait out the block before a register write
  task automatic idle_wait();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_pts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    idle_wait();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDegree) shadow_degree = val[1:0];
    else shadow_count = val;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 1023)) - 512);
      default: return 24'($urandom());
    endcase
  endfunction

  // Parameter with integer part up to the point count plus three (at most 63), random fraction
  function automatic logic [21:0] reach_u();
    int top;
    top = shadow_count + 3;
    if (top > 63) top = 63;
    return {6'($urandom_range(0, top)), 16'($urandom())};
  endfunction

  // Fill every slot so no evaluation ever reads an unwritten entry
  task automatic test_load_table();
    for (int i = 0; i < MaxPoints; i++) write_point(i, rand_coord(), rand_coord());
  endtask

  // Field extremes, all degrees, no points, saturation
  task automatic test_corners();
    write_cfg(CfgCount, 7'd0);
    eval_at(22'd0);
    eval_at(22'h3FFFFF);
    write_cfg(CfgCount, 7'd4);
    write_point(0, 24'sh7FFFFF, 24'sh800000);
    write_point(1, 24'sh7FFFFF, 24'sh800000);
    write_point(2, 24'sh7FFFFF, 24'sh800000);
    write_point(63, 24'sh800000, 24'sh7FFFFF);
    for (int d = 0; d < 4; d++) begin
      write_cfg(CfgDegree, 7'(d));
      eval_at(22'h010000);
      eval_at(22'h028000);
      eval_at(22'h02FFFF);
      eval_at(22'h3FFFFF);
    end
    write_cfg(CfgCount, 7'd127);
    eval_at(22'h3FFFFF);
    eval_at(22'h3F8000);
  endtask

  // Mixed writes and evaluations across several settings
  task automatic test_random(int n_items);
    int per_phase;
    per_phase = n_items / 8;
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CfgDegree, 7'($urandom_range(0, 3)));
      case (ph)
        0: write_cfg(CfgCount, 7'd1);
        1: write_cfg(CfgCount, 7'd64);
        2: write_cfg(CfgCount, 7'd127);
        3: write_cfg(CfgCount, 7'd0);
        default: write_cfg(CfgCount, 7'($urandom_range(0, 127)));
      endcase
      for (int k = 0; k < per_phase; k++) begin
        case ($urandom_range(0, 9))
          0, 1: write_point(int'($urandom_range(0, 63)), rand_coord(), rand_coord());
          2: eval_at(22'($urandom()));
          default: eval_at(reach_u());
        endcase
      end
    end
  endtask

  // Result side: stall pattern, check at the falling edge before acceptance
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt[11:9] == 3'd0) out_if.ready <= 1'b1;
    else if (stall_cnt[8]) out_if.ready <= ($urandom_range(0, 3) != 0);
    else out_if.ready <= ($urandom_range(0, 2) == 0);
  end

  always @(negedge clk_i) begin
    curve_pt_t exp_pt;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pts.size() == 0) begin
        $display("%0t: unexpected curve beat x=%0d y=%0d", $time, out_if.curve_x,
                 out_if.curve_y);
        n_errors++;
      end else begin
        exp_pt = expected_pts.pop_front();
        if (out_if.curve_x !== exp_pt.x) begin
          $display("%0t: curve_x expected %0d actual %0d", $time, exp_pt.x, out_if.curve_x);
          n_errors++;
        end
        if (out_if.curve_y !== exp_pt.y) begin
          $display("%0t: curve_y expected %0d actual %0d", $time, exp_pt.y, out_if.curve_y);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    shadow_degree = 2'd3;
    shadow_count = 7'd0;
    for (int i = 0; i < MaxPoints; i++) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_table();
    test_corners();
    test_random(860);
    idle_wait();
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_if.sv
hw/rtl/bsc_mul.sv
hw/rtl/bsc_basis.sv
hw/rtl/bspline_curve_point_eval.sv
sim/bspline_curve_point_eval_tb.sv
